FILE: hdl/sacmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacmc_pkg: shared types and constants of the cache miss classifier
// Geometry defaults, outcome and policy codes, register indexes.
// ----------------------------------------------------------------------------
package sacmc_pkg;

    localparam int MAX_WAYS_DEF = 8;
    localparam int MAX_SETS_DEF = 1024;
    localparam int STAMP_W      = 32;
    localparam int TAG_W        = 32;
    localparam int CNT_W        = 32;

    // outcome codes
    localparam logic [1:0] OUT_HIT  = 2'd0;
    localparam logic [1:0] OUT_COMP = 2'd1;
    localparam logic [1:0] OUT_CONF = 2'd2;
    localparam logic [1:0] OUT_CAP  = 2'd3;

    // replacement policies
    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_LRU    = 2'd2;
    localparam logic [1:0] POL_KEEP   = 2'd3;   // classify only, never replace

    // register indexes
    localparam logic [2:0] REG_OFFSET = 3'd0;
    localparam logic [2:0] REG_INDEX  = 3'd1;
    localparam logic [2:0] REG_WAYS   = 3'd2;
    localparam logic [2:0] REG_POLICY = 3'd3;
    localparam logic [2:0] REG_SEED   = 3'd4;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // one stored entry: valid bit, tag, fill and use stamps
    typedef struct packed {
        logic               vld;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] fill;
        logic [STAMP_W-1:0] used;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

FILE: hdl/sacmc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacmc_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sacmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: hdl/set_assoc_cache_miss_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_miss_classifier: set-associative cache miss classifier
//
// Usage: one 32-bit byte address enters per word on the in channel
// (in_valid / in_stall); one result word leaves on the out channel
// (out_valid / out_stall) with outcome, way, set and saturating counters.
// Valid bits, tags and stamps sit in one single-port RAM of
// MAX_SETS*MAX_WAYS entries.
// From acceptance to the result word in the output register, the ways of the
// set are read one a cycle through the RAM port (ST_READ), the last data
// returns (ST_ADDR), the outcome is decided (ST_DEC) and the entry is written
// back (ST_WRITE). The next address is taken only once the engine is back in ST_IDLE.
// A stalled receiver holds the word in the output register; the engine then
// waits in write-back and in_stall stays high until the word leaves.
// Reset and any write to a geometry register start a clearing pass over the
// whole RAM, all MAX_SETS*MAX_WAYS entries (8192 by default), with in_stall high.
// Reset also clears the counters and loads the LFSR with 1.
// ----------------------------------------------------------------------------
module set_assoc_cache_miss_classifier #(
    parameter int MAX_WAYS = sacmc_pkg::MAX_WAYS_DEF,
    parameter int MAX_SETS = sacmc_pkg::MAX_SETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  outcome,
    output logic [2:0]  way,
    output logic [9:0]  set_index,
    output logic [31:0] total_accesses,
    output logic [31:0] total_hits,
    output logic [31:0] total_compulsory,
    output logic [31:0] total_conflict,
    output logic [31:0] total_capacity
);
    localparam int WB    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SB    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SLOGM = $clog2(MAX_SETS + 1) - 1;   // floor log2
    localparam int DEPTH = MAX_SETS * MAX_WAYS;
    localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FB    = $clog2(DEPTH + 1);
    localparam int WC    = $clog2(MAX_WAYS + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ADDR  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_DEC   = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_CLEAR = 6'b100000
    } state_t;

    // configuration
    logic [3:0]  offset_bits_reg, index_bits_reg;
    logic [1:0]  ways_log2_reg, policy_reg;
    logic [15:0] lfsr_reg;
    logic        flush;

    // engine
    state_t            state_reg;
    logic [AB-1:0]     clr_reg;
    logic [SB-1:0]     set_reg;
    logic [31:0]       tag_reg;
    logic [WC-1:0]     nways_reg;
    logic [WB-1:0]     rd_way_reg;     // way being addressed
    logic [WB-1:0]     chk_way_reg;    // way whose data returns
    logic              chk_pend_reg;
    logic              found_reg;
    logic [1:0]        res_out_reg;
    logic [WB-1:0]     res_way_reg;
    logic [WB-1:0]     best_way_reg;
    logic [31:0]       best_stamp_reg;
    sacmc_pkg::entry_t hit_entry_reg;
    logic [FB-1:0]     filled_reg;
    logic [31:0]       acc_reg, hit_reg, comp_reg, conf_reg, cap_reg;

    // output word
    logic        ov_reg;
    logic        out_load;
    logic [1:0]  o_out_reg;
    logic [2:0]  o_way_reg;
    logic [9:0]  o_set_reg;
    logic [31:0] o_acc_reg, o_hit_reg, o_comp_reg, o_conf_reg, o_cap_reg;

    // ram
    logic              ram_we;
    logic [AB-1:0]     ram_addr;
    sacmc_pkg::entry_t ram_wdata, ram_rdata;

    sacmc_ram #(.WIDTH(sacmc_pkg::ENTRY_W), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // derived geometry
    logic [3:0]  ib_eff;
    logic [5:0]  tag_shift;
    logic [31:0] set_mask;
    logic [31:0] in_set_full;
    logic [AB-1:0] rd_slot;
    logic [4:0]  rnd_tmp;
    logic [WB-1:0] rnd_way;
    logic [15:0] lfsr_adv;
    logic [FB:0] cap_total;
    logic        entry_valid;
    logic        is_lru;
    logic [31:0] cand_stamp;
    logic [WB-1:0] victim;
    logic [31:0] new_acc;

    always_comb
    begin
        ib_eff     = (index_bits_reg > 4'(SLOGM)) ? 4'(SLOGM) : index_bits_reg;
        tag_shift  = 6'(offset_bits_reg) + 6'(ib_eff);
        set_mask   = (32'd1 << ib_eff) - 32'd1;
        in_set_full = (address >> offset_bits_reg) & set_mask;
        rd_slot    = AB'(set_reg) * AB'(MAX_WAYS) + AB'(rd_way_reg);
        // random way: LFSR masked to the way count, folded into the ways in use
        rnd_tmp    = 5'(lfsr_reg[2:0] & 3'((4'd1 << ways_log2_reg) - 4'd1));
        for (int i = 0; i < 7; i++)
        begin
            if (rnd_tmp >= 5'(nways_reg))
            begin
                rnd_tmp = rnd_tmp - 5'(nways_reg);
            end
        end
        rnd_way    = WB'(rnd_tmp);
        lfsr_adv   = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ sacmc_pkg::LFSR_TAPS)
                                 : (lfsr_reg >> 1);
        cap_total  = (FB+1)'(32'(nways_reg) << ib_eff);
        entry_valid = ram_rdata.vld;
        is_lru     = (policy_reg == sacmc_pkg::POL_LRU);
        cand_stamp = is_lru ? ram_rdata.used : ram_rdata.fill;
        case (policy_reg)
            sacmc_pkg::POL_RANDOM: victim = rnd_way;
            sacmc_pkg::POL_FIFO,
            sacmc_pkg::POL_LRU:    victim = best_way_reg;
            default:               victim = '0;
        endcase
        new_acc    = sacmc_pkg::sat_inc(acc_reg);
    end

    assign flush    = cfg_we && (cfg_index == sacmc_pkg::REG_OFFSET
                    || cfg_index == sacmc_pkg::REG_INDEX
                    || cfg_index == sacmc_pkg::REG_WAYS);
    assign in_stall = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign out_load = (state_reg == ST_WRITE) && (!ov_reg || !out_stall);

    // ram access
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = rd_slot;
        ram_wdata = hit_entry_reg;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_WRITE && res_out_reg == sacmc_pkg::OUT_HIT)
        begin
            ram_we   = 1'b1;
            ram_addr = AB'(set_reg) * AB'(MAX_WAYS) + AB'(res_way_reg);
            ram_wdata.used = acc_reg;
        end
        else if (state_reg == ST_WRITE && (policy_reg != sacmc_pkg::POL_KEEP
                 || res_out_reg == sacmc_pkg::OUT_COMP))
        begin
            ram_we   = 1'b1;
            ram_addr = AB'(set_reg) * AB'(MAX_WAYS) + AB'(res_way_reg);
            ram_wdata.vld  = 1'b1;
            ram_wdata.tag  = tag_reg;
            ram_wdata.fill = acc_reg;
            ram_wdata.used = acc_reg;
        end
    end

    // configuration and engine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 4'd2;
            index_bits_reg  <= 4'd6;
            ways_log2_reg   <= 2'd2;
            policy_reg      <= sacmc_pkg::POL_LRU;
            lfsr_reg        <= 16'd1;
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            filled_reg      <= '0;
            acc_reg         <= '0;
            hit_reg         <= '0;
            comp_reg        <= '0;
            conf_reg        <= '0;
            cap_reg         <= '0;
            ov_reg          <= 1'b0;
            found_reg       <= 1'b0;
            chk_pend_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sacmc_pkg::REG_OFFSET: offset_bits_reg <= cfg_data[3:0];
                    sacmc_pkg::REG_INDEX:  index_bits_reg  <= cfg_data[3:0];
                    sacmc_pkg::REG_WAYS:   ways_log2_reg   <= cfg_data[1:0];
                    sacmc_pkg::REG_POLICY: policy_reg      <= cfg_data[1:0];
                    sacmc_pkg::REG_SEED:
                        lfsr_reg <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
                    default: ;
                endcase
            end

            // output word register
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end

            if (flush)
            begin
                // geometry change: empty the cache with a fresh clearing pass
                filled_reg <= '0;
                clr_reg    <= '0;
                state_reg  <= ST_CLEAR;
            end
            else
            begin
                case (state_reg)
                    ST_CLEAR:
                    begin
                        if (clr_reg == AB'(DEPTH - 1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            clr_reg <= clr_reg + 1'b1;
                        end
                    end
                    ST_IDLE:
                    begin
                        if (in_valid && !in_stall)
                        begin
                            set_reg   <= SB'(in_set_full);
                            tag_reg   <= 32'({32'd0, address} >> tag_shift);
                            nways_reg <= ((32'd1 << ways_log2_reg) > 32'(MAX_WAYS))
                                         ? WC'(MAX_WAYS) : WC'(32'd1 << ways_log2_reg);
                            acc_reg   <= new_acc;
                            rd_way_reg <= '0;
                            found_reg <= 1'b0;
                            chk_pend_reg <= 1'b0;
                            best_way_reg <= '0;
                            state_reg <= ST_READ;
                        end
                    end
                    ST_READ:
                    begin
                        // data of chk_way returns this cycle if pending
                        if (chk_pend_reg && !found_reg)
                        begin
                            if (!entry_valid)
                            begin
                                found_reg   <= 1'b1;
                                res_out_reg <= sacmc_pkg::OUT_COMP;
                                res_way_reg <= chk_way_reg;
                            end
                            else if (ram_rdata.tag == tag_reg)
                            begin
                                found_reg     <= 1'b1;
                                res_out_reg   <= sacmc_pkg::OUT_HIT;
                                res_way_reg   <= chk_way_reg;
                                hit_entry_reg <= ram_rdata;
                            end
                            else if (chk_way_reg == '0 || cand_stamp < best_stamp_reg)
                            begin
                                best_way_reg   <= chk_way_reg;
                                best_stamp_reg <= cand_stamp;
                            end
                        end
                        chk_way_reg  <= rd_way_reg;
                        chk_pend_reg <= 1'b1;
                        if ((WC+1)'(rd_way_reg) + (WC+1)'(1) == (WC+1)'(nways_reg))
                        begin
                            state_reg <= ST_ADDR;
                        end
                        else
                        begin
                            rd_way_reg <= rd_way_reg + 1'b1;
                        end
                    end
                    ST_ADDR:
                    begin
                        // last way returns here
                        if (!found_reg)
                        begin
                            if (!entry_valid)
                            begin
                                found_reg   <= 1'b1;
                                res_out_reg <= sacmc_pkg::OUT_COMP;
                                res_way_reg <= chk_way_reg;
                            end
                            else if (ram_rdata.tag == tag_reg)
                            begin
                                found_reg     <= 1'b1;
                                res_out_reg   <= sacmc_pkg::OUT_HIT;
                                res_way_reg   <= chk_way_reg;
                                hit_entry_reg <= ram_rdata;
                            end
                            else if (chk_way_reg == '0 || cand_stamp < best_stamp_reg)
                            begin
                                best_way_reg   <= chk_way_reg;
                                best_stamp_reg <= cand_stamp;
                            end
                        end
                        state_reg <= ST_DEC;
                    end
                    ST_DEC:
                    begin
                        if (!found_reg)
                        begin
                            res_out_reg <= ({1'b0, filled_reg} < cap_total)
                                           ? sacmc_pkg::OUT_CONF : sacmc_pkg::OUT_CAP;
                            res_way_reg <= victim;
                            if (policy_reg == sacmc_pkg::POL_RANDOM)
                            begin
                                lfsr_reg <= lfsr_adv;
                            end
                        end
                        state_reg <= ST_WRITE;
                    end
                    ST_WRITE:
                    begin
                        if (out_load)
                        begin
                            case (res_out_reg)
                                sacmc_pkg::OUT_HIT:  hit_reg  <= sacmc_pkg::sat_inc(hit_reg);
                                sacmc_pkg::OUT_COMP: comp_reg <= sacmc_pkg::sat_inc(comp_reg);
                                sacmc_pkg::OUT_CONF: conf_reg <= sacmc_pkg::sat_inc(conf_reg);
                                default:             cap_reg  <= sacmc_pkg::sat_inc(cap_reg);
                            endcase
                            if (res_out_reg == sacmc_pkg::OUT_COMP)
                            begin
                                filled_reg <= filled_reg + 1'b1;
                            end
                            o_out_reg  <= res_out_reg;
                            o_way_reg  <= (res_out_reg[1]
                                           && policy_reg == sacmc_pkg::POL_KEEP)
                                          ? 3'd0 : 3'(res_way_reg);
                            o_set_reg  <= 10'(set_reg);
                            o_acc_reg  <= acc_reg;
                            o_hit_reg  <= (res_out_reg == sacmc_pkg::OUT_HIT)
                                          ? sacmc_pkg::sat_inc(hit_reg) : hit_reg;
                            o_comp_reg <= (res_out_reg == sacmc_pkg::OUT_COMP)
                                          ? sacmc_pkg::sat_inc(comp_reg) : comp_reg;
                            o_conf_reg <= (res_out_reg == sacmc_pkg::OUT_CONF)
                                          ? sacmc_pkg::sat_inc(conf_reg) : conf_reg;
                            o_cap_reg  <= (res_out_reg == sacmc_pkg::OUT_CAP)
                                          ? sacmc_pkg::sat_inc(cap_reg) : cap_reg;
                            state_reg  <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    assign out_valid        = ov_reg;
    assign outcome          = o_out_reg;
    assign way              = o_way_reg;
    assign set_index        = o_set_reg;
    assign total_accesses   = o_acc_reg;
    assign total_hits       = o_hit_reg;
    assign total_compulsory = o_comp_reg;
    assign total_conflict   = o_conf_reg;
    assign total_capacity   = o_cap_reg;
endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the set-associative cache miss classifier
// Drives address words with random gaps, stalls the result channel at random
// and checks every result word field by field against a behavioural model of
// the tag store, replacement policies and saturating counters kept here.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SETS_CAP   = 1024;
    localparam int WAYS_CAP   = 8;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 30;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [2:0]  way;
        logic [9:0]  set_index;
        logic [31:0] accesses;
        logic [31:0] hits;
        logic [31:0] compulsory;
        logic [31:0] conflict;
        logic [31:0] capacity;
    } access_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  outcome;
    logic [2:0]  way;
    logic [9:0]  set_index;
    logic [31:0] total_accesses, total_hits, total_compulsory;
    logic [31:0] total_conflict, total_capacity;

    set_assoc_cache_miss_classifier dut (.*);

    always #2 clk = ~clk;

    // model state
    logic [31:0] m_tag  [SETS_CAP*WAYS_CAP];
    logic [31:0] m_fill [SETS_CAP*WAYS_CAP];
    logic [31:0] m_used [SETS_CAP*WAYS_CAP];
    bit          m_valid[SETS_CAP*WAYS_CAP];
    int unsigned m_filled;
    logic [31:0] m_acc, m_hit, m_comp, m_conf, m_cap;
    logic [15:0] m_lfsr;
    logic [3:0]  m_off, m_idx;
    logic [1:0]  m_ways, m_policy;

    access_result_t expected_results[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  calm = 1'b0;        // no idling on either side
    bit  long_hold = 1'b0;   // receiver holds off for a long stretch

    function automatic logic [31:0] sat_step(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int unsigned index_in_use();
        return (m_idx > 10) ? 10 : m_idx;
    endfunction

    function automatic int unsigned oldest_way(input bit by_fill, input int unsigned base,
                                               input int unsigned nways);
        int unsigned best = 0;
        for (int unsigned w = 1; w < nways; w++)
        begin
            if (by_fill ? (m_fill[base+w] < m_fill[base+best])
                        : (m_used[base+w] < m_used[base+best]))
                best = w;
        end
        return best;
    endfunction

    // classify one access and update the model cache
    function automatic access_result_t classify_access(input logic [31:0] addr);
        access_result_t r;
        int unsigned ib, nsets, nways, set, base, w;
        logic [31:0] tag;
        bit found = 1'b0;
        ib    = index_in_use();
        nsets = 1 << ib;
        nways = 1 << m_ways;
        set   = 32'((64'(addr) >> m_off) & 64'(nsets - 1));
        tag   = 32'(64'(addr) >> (m_off + ib));
        base  = set * WAYS_CAP;
        m_acc = sat_step(m_acc);
        r = '0;
        for (w = 0; w < nways && !found; w++)
        begin
            if (!m_valid[base+w])
            begin
                m_tag[base+w] = tag;
                m_fill[base+w] = m_acc;
                m_used[base+w] = m_acc;
                m_valid[base+w] = 1'b1;
                m_filled++;
                m_comp = sat_step(m_comp);
                r.outcome = sacmc_pkg::OUT_COMP;
                r.way = 3'(w);
                found = 1'b1;
            end
            else if (m_tag[base+w] == tag)
            begin
                m_used[base+w] = m_acc;
                m_hit = sat_step(m_hit);
                r.outcome = sacmc_pkg::OUT_HIT;
                r.way = 3'(w);
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (m_filled < nsets * nways)
            begin
                m_conf = sat_step(m_conf);
                r.outcome = sacmc_pkg::OUT_CONF;
            end
            else
            begin
                m_cap = sat_step(m_cap);
                r.outcome = sacmc_pkg::OUT_CAP;
            end
            w = 0;
            case (m_policy)
                sacmc_pkg::POL_RANDOM:
                begin
                    w = m_lfsr & (nways - 1);
                    m_lfsr = m_lfsr[0] ? ((m_lfsr >> 1) ^ sacmc_pkg::LFSR_TAPS)
                                       : (m_lfsr >> 1);
                end
                sacmc_pkg::POL_FIFO: w = oldest_way(1'b1, base, nways);
                sacmc_pkg::POL_LRU:  w = oldest_way(1'b0, base, nways);
                default:             w = 0;
            endcase
            if (m_policy != sacmc_pkg::POL_KEEP)
            begin
                m_tag[base+w] = tag;
                m_fill[base+w] = m_acc;
                m_used[base+w] = m_acc;
            end
            r.way = 3'(w);
        end
        r.set_index = 10'(set);
        r.accesses = m_acc;
        r.hits = m_hit;
        r.compulsory = m_comp;
        r.conflict = m_conf;
        r.capacity = m_cap;
        return r;
    endfunction

    // present one address word, record its prediction on acceptance
    task automatic send_word(input logic [31:0] addr);
        int gap;
        gap = calm ? 0 : $urandom_range(10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        address  <= addr;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(classify_access(addr));
    endtask

    // let every outstanding result arrive, then let the engine settle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            sacmc_pkg::REG_OFFSET: m_off = value[3:0];
            sacmc_pkg::REG_INDEX:  m_idx = value[3:0];
            sacmc_pkg::REG_WAYS:   m_ways = value[1:0];
            sacmc_pkg::REG_POLICY: m_policy = value[1:0];
            sacmc_pkg::REG_SEED:   m_lfsr = (value == 16'd0) ? 16'd1 : value;
            default: ;
        endcase
        if (idx <= sacmc_pkg::REG_WAYS)
        begin
            foreach (m_valid[i]) m_valid[i] = 1'b0;
            m_filled = 0;
        end
    endtask

    task automatic set_geometry(input int off, input int idx, input int wl, input int pol);
        write_reg(sacmc_pkg::REG_OFFSET, 16'(off));
        write_reg(sacmc_pkg::REG_INDEX, 16'(idx));
        write_reg(sacmc_pkg::REG_WAYS, 16'(wl));
        write_reg(sacmc_pkg::REG_POLICY, 16'(pol));
    endtask

    // address built from a small tag pool so that hits and evictions recur
    function automatic logic [31:0] pooled_address(input int unsigned pool);
        int unsigned ib;
        logic [63:0] a;
        ib = index_in_use();
        a = (64'($urandom_range(pool)) << (m_off + ib))
          | (64'($urandom) & ((64'd1 << (m_off + ib)) - 1));
        return a[31:0];
    endfunction

    task automatic run_mix(input int count, input int unsigned pool);
        repeat (count)
        begin
            if ($urandom_range(9) < 8)
                send_word(pooled_address(pool));
            else
                send_word($urandom);
        end
    endtask

    // reset geometry: fills, hits, a full set and address extremes
    task automatic test_reset_defaults();
        send_word(32'h0000_0000);
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        for (int t = 1; t <= 5; t++) send_word(32'(t << 8));
        send_word(32'h0000_0100);
        send_word(32'h7FFF_FFFF);
    endtask

    // every policy including the one that never replaces
    task automatic test_policies();
        for (int p = 0; p < 4; p++)
        begin
            set_geometry(0, 0, 1, p);
            send_word(32'd1);
            send_word(32'd2);
            send_word(32'd1);
            send_word(32'd3);
            send_word(32'd4);
            send_word(32'd2);
        end
    endtask

    // field extremes: wide offset, clipped index, one and eight ways, zero seed
    task automatic test_geometry_extremes();
        set_geometry(15, 15, 3, sacmc_pkg::POL_RANDOM);
        write_reg(sacmc_pkg::REG_SEED, 16'd0);
        write_reg(3'd7, 16'hFFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_8000);
        send_word(32'hFFFF_7FFF);
        set_geometry(12, 10, 0, sacmc_pkg::POL_RANDOM);
        write_reg(sacmc_pkg::REG_SEED, 16'hFFFF);
        send_word(32'hA5A5_A5A5);
        send_word(32'h5A5A_5A5A);
        send_word(32'hA5A5_A5A5);
    endtask

    task automatic test_random_phases();
        int off, idx, wl, pol;
        for (int ph = 0; ph < 11; ph++)
        begin
            off = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(4);
            idx = (ph == 5) ? 15 : $urandom_range(4);
            wl  = (ph == 2) ? 3 : $urandom_range(3);
            pol = $urandom_range(3);
            set_geometry(off, idx, wl, pol);
            write_reg(sacmc_pkg::REG_SEED, 16'($urandom_range(65535, 1)));
            calm = (ph == 3);
            run_mix(157, (2 << wl) + 1);
            calm = 1'b0;
        end
    endtask

    // long receiver hold-off while words keep coming, then a sender pause
    task automatic test_backpressure();
        set_geometry(2, 2, 2, sacmc_pkg::POL_LRU);
        long_hold = 1'b1;
        run_mix(40, 9);
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        run_mix(40, 9);
    endtask

    // result channel: random stall before each word, plus the long hold
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else
            begin
                k = calm ? 0 : $urandom_range(10);
                if (k > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (k) @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
            while (!out_valid) @(posedge clk);
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        access_result_t e, a;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            a = {outcome, way, set_index, total_accesses, total_hits, total_compulsory,
                 total_conflict, total_capacity};
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, a);
                fail_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (a !== e)
                begin
                    fail_count++;
                    $display("%0t: outcome exp %0d got %0d, way exp %0d got %0d, set exp %0d got %0d",
                             $time, e.outcome, a.outcome, e.way, a.way, e.set_index, a.set_index);
                    $display("%0t: counts exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                             $time, e.accesses, e.hits, e.compulsory, e.conflict, e.capacity,
                             a.accesses, a.hits, a.compulsory, a.conflict, a.capacity);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        m_off = 4'd2;
        m_idx = 4'd6;
        m_ways = 2'd2;
        m_policy = sacmc_pkg::POL_LRU;
        m_lfsr = 16'd1;
        m_filled = 0;
        {m_acc, m_hit, m_comp, m_conf, m_cap} = '0;
        foreach (m_valid[i]) m_valid[i] = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_policies();
        test_geometry_extremes();
        test_random_phases();
        test_backpressure();
        drain();
        if (expected_results.size() == 0 && fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

FILE: files.f
hdl/sacmc_pkg.sv
hdl/sacmc_ram.sv
hdl/set_assoc_cache_miss_classifier.sv
test/testbench.sv
